// ===== rtl/crc8d_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the packet deframer.
package crc8d_pkg;

	// Frame bytes
	localparam logic [7:0] HDR_BYTE = 8'hAA;
	localparam logic [7:0] FTR_BYTE = 8'h55;
	localparam logic [7:0] ACK_OK   = 8'h01;
	localparam logic [7:0] ACK_BAD  = 8'h00;
	localparam logic [7:0] ACK_LEN  = 8'h03;

	// Register reset values
	localparam logic [7:0] POLY_RESET = 8'h07;

	// Depth of the ack queue between parser and sender
	localparam int QUEUE_DEPTH = 2;

	// Register indexes
	typedef enum logic [1:0] {
		REG_POLY,
		REG_INIT,
		REG_FXOR,
		REG_ACKCMD
	} reg_idx_t;

	// Parser phases
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_COMMAND,
		PH_PAYLOAD,
		PH_CRC,
		PH_FOOTER
	} phase_t;

	// Positions inside the acknowledge frame
	typedef enum logic [2:0] {
		AB_HDR,
		AB_LEN,
		AB_CMD,
		AB_STATUS,
		AB_CRC,
		AB_FTR
	} ack_pos_t;

	// Configuration registers
	typedef struct packed {
		logic [7:0] poly;
		logic [7:0] init;
		logic [7:0] fxor;
		logic [7:0] ack_cmd;
	} cfg_t;

	// One completed frame, waiting to be acknowledged
	typedef struct packed {
		logic [7:0] command;
		logic [7:0] count;
		logic       good;
	} desc_t;

	// MSB-first CRC-8 update over one byte
	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ poly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/crc8d_front.sv =====
// Front end: parses received bytes, runs the CRC and posts completed frames.
module crc8d_front (
	input  logic              clk,
	input  logic              arst_n,
	input  crc8d_pkg::cfg_t   cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	input  logic              q_full,
	output logic              q_push,
	output crc8d_pkg::desc_t  q_desc
);
	import crc8d_pkg::*;

	phase_t     phase_q;
	phase_t     phase_d;
	logic [7:0] count_q;
	logic [7:0] command_q;
	logic [7:0] left_q;
	logic [7:0] crc_q;
	logic [7:0] crc_rx_q;
	logic       acc;

	// Stall only when a footer would need a queue slot that is not there
	assign in_ready = (phase_q != PH_FOOTER) || !q_full;
	assign acc      = in_valid && in_ready;

	// Post a descriptor on a good footer
	assign q_push       = acc && (phase_q == PH_FOOTER) && (rx_byte == FTR_BYTE);
	assign q_desc.command = command_q;
	assign q_desc.count   = count_q;
	assign q_desc.good    = (crc_rx_q == (crc_q ^ cfg.fxor));

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
		end else if (acc) begin
			phase_q <= phase_d;
		end
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HEADER: begin
				if (rx_byte == HDR_BYTE) begin
					phase_d = PH_LENGTH;
				end
			end
			PH_LENGTH:  phase_d = PH_COMMAND;
			PH_COMMAND: phase_d = (count_q != 8'd0) ? PH_PAYLOAD : PH_CRC;
			PH_PAYLOAD: begin
				if (left_q == 8'd1) begin
					phase_d = PH_CRC;
				end
			end
			PH_CRC:     phase_d = PH_FOOTER;
			PH_FOOTER:  phase_d = PH_HEADER;
			default:    phase_d = PH_HEADER;
		endcase
	end

	// Frame fields and running CRC
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= 8'd0;
			command_q <= 8'd0;
			left_q    <= 8'd0;
			crc_q     <= 8'd0;
			crc_rx_q  <= 8'd0;
		end else if (acc) begin
			case (phase_q)
				PH_LENGTH: begin
					// length counts payload plus two
					count_q <= (rx_byte >= 8'd2) ? (rx_byte - 8'd2) : 8'd0;
				end
				PH_COMMAND: begin
					command_q <= rx_byte;
					crc_q     <= crc_byte(cfg.init, rx_byte, cfg.poly);
					left_q    <= count_q;
				end
				PH_PAYLOAD: begin
					crc_q  <= crc_byte(crc_q, rx_byte, cfg.poly);
					left_q <= left_q - 8'd1;
				end
				PH_CRC: begin
					crc_rx_q <= rx_byte;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/crc8d_queue.sv =====
// Small register queue of frame descriptors between front and back.
module crc8d_queue #(
	parameter int DEPTH = crc8d_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  crc8d_pkg::desc_t  push_desc,
	output logic              full,
	input  logic              pop,
	output logic              q_valid,
	output crc8d_pkg::desc_t  q_desc
);
	import crc8d_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	desc_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_desc  = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== rtl/crc8d_back.sv =====
// Back end: turns each descriptor into the six bytes of an acknowledge frame.
module crc8d_back (
	input  logic              clk,
	input  logic              arst_n,
	input  crc8d_pkg::cfg_t   cfg,
	input  logic              q_valid,
	input  crc8d_pkg::desc_t  q_desc,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        tx_byte,
	output logic [7:0]        frame_command,
	output logic [7:0]        payload_count,
	output logic              crc_good,
	output logic              last_byte
);
	import crc8d_pkg::*;

	desc_t      desc_q;
	logic       busy_q;
	ack_pos_t   pos_q;
	logic [7:0] crc_cmd_q;
	logic       out_valid_q;
	logic [7:0] tx_q;
	logic [7:0] cmd_q;
	logic [7:0] cnt_q;
	logic       good_q;
	logic       last_q;
	logic       slot_free;
	logic       load;
	logic [7:0] status;
	logic [7:0] byte_d;

	assign slot_free = !out_valid_q || out_ready;
	assign load      = busy_q && slot_free;
	assign q_pop     = q_valid && !busy_q;
	assign status    = desc_q.good ? ACK_OK : ACK_BAD;

	// CRC of the ack command byte, from the current settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_cmd_q <= 8'd0;
		end else begin
			crc_cmd_q <= crc_byte(cfg.init, cfg.ack_cmd, cfg.poly);
		end
	end

	// Byte for the current frame position
	always_comb begin
		case (pos_q)
			AB_HDR:    byte_d = HDR_BYTE;
			AB_LEN:    byte_d = ACK_LEN;
			AB_CMD:    byte_d = cfg.ack_cmd;
			AB_STATUS: byte_d = status;
			AB_CRC:    byte_d = crc_byte(crc_cmd_q, status, cfg.poly) ^ cfg.fxor;
			AB_FTR:    byte_d = FTR_BYTE;
			default:   byte_d = FTR_BYTE;
		endcase
	end

	// Descriptor and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= AB_HDR;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			pos_q  <= AB_HDR;
		end else if (load) begin
			if (pos_q == AB_FTR) begin
				busy_q <= 1'b0;
			end
			pos_q <= ack_pos_t'(pos_q + 3'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			desc_q <= q_desc;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tx_q   <= byte_d;
			cmd_q  <= desc_q.command;
			cnt_q  <= desc_q.count;
			good_q <= desc_q.good;
			last_q <= (pos_q == AB_FTR);
		end
	end

	assign out_valid     = out_valid_q;
	assign tx_byte       = tx_q;
	assign frame_command = cmd_q;
	assign payload_count = cnt_q;
	assign crc_good      = good_q;
	assign last_byte     = last_q;

endmodule

// ===== rtl/crc8_packet_deframer_with_ack_top.sv =====
// Throughput: one received byte per cycle; input stalls only on a footer while the queue is full.
// Ack path: each accepted frame passes the queue and the sender's output register; the sender
// gives one ack byte per cycle while out_ready holds, six per frame, with a gap between frames.
// The ack queue holds QUEUE_DEPTH pending frames before the parser must wait.
// Reset (arst_n low, asynchronous): parser waits for header, queue empty, output idle,
// registers at polynomial 0x07, others zero.
module crc8_packet_deframer_with_ack_top #(
	parameter int QUEUE_DEPTH = crc8d_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] tx_byte,
	output logic [7:0] frame_command,
	output logic [7:0] payload_count,
	output logic       crc_good,
	output logic       last_byte
);
	import crc8d_pkg::*;

	cfg_t  cfg_q;
	desc_t push_desc;
	desc_t pop_desc;
	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_valid;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly    <= POLY_RESET;
			cfg_q.init    <= 8'd0;
			cfg_q.fxor    <= 8'd0;
			cfg_q.ack_cmd <= 8'd0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_POLY:   cfg_q.poly    <= cfg_data;
				REG_INIT:   cfg_q.init    <= cfg_data;
				REG_FXOR:   cfg_q.fxor    <= cfg_data;
				REG_ACKCMD: cfg_q.ack_cmd <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	crc8d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_desc   (push_desc)
	);

	crc8d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (q_pop),
		.q_valid   (q_valid),
		.q_desc    (pop_desc)
	);

	crc8d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_desc        (pop_desc),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tx_byte       (tx_byte),
		.frame_command (frame_command),
		.payload_count (payload_count),
		.crc_good      (crc_good),
		.last_byte     (last_byte)
	);

`ifndef ASSERT_OFF
	// A frame is never posted into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("ack queue overflow");

	// The parser stalls only because the queue is full
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_full)
		else $error("input stalled with queue space free");

	// The closing ack item carries the footer byte
	a_last_is_footer: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_byte) |-> (tx_byte == FTR_BYTE))
		else $error("last ack item is not the footer");

	// A posted frame reaches the sender side the next cycle
	a_post_seen: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> q_valid)
		else $error("posted frame not visible in queue");
`endif

endmodule
